>>> hw/rtl/ksdp_pkg.sv
package ksdp_pkg;

    // Table geometry
    localparam int MAX_CAPACITY = 1023;
    localparam int DEPTH        = MAX_CAPACITY + 1;
    localparam int ADDR_W       = $clog2(DEPTH);

    // Field widths
    localparam int CAP_W     = 10;
    localparam int WEIGHT_W  = 10;
    localparam int VALUE_W   = 16;
    localparam int BEST_W    = 32;
    localparam int S_TDATA_W = ((WEIGHT_W + VALUE_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((BEST_W + 7) / 8) * 8;

    // Front-to-back queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // One classified object on its way to the sweep engine
    typedef struct packed {
        logic                last;
        logic                fits;   // weight <= capacity, so a sweep is needed
        logic [ADDR_W-1:0]   cap;    // effective capacity at transfer time
        logic [VALUE_W-1:0]  value;
        logic [WEIGHT_W-1:0] weight;
    } item_t;

    typedef struct packed {
        logic clearing;
    } back_status_t;

    function automatic logic [ADDR_W-1:0] eff_capacity(input logic [CAP_W-1:0] cap);
        int unsigned c;
        c = 32'(cap);
        if (c > MAX_CAPACITY) begin
            c = MAX_CAPACITY;
        end
        return ADDR_W'(c);
    endfunction

    function automatic logic [BEST_W-1:0] sat_add(input logic [BEST_W-1:0] a,
                                                  input logic [VALUE_W-1:0] b);
        logic [BEST_W:0] s;
        s = {1'b0, a} + (BEST_W + 1)'(b);
        return s[BEST_W] ? {BEST_W{1'b1}} : s[BEST_W-1:0];
    endfunction

endpackage

>>> hw/rtl/ksdp_front.sv
module ksdp_front import ksdp_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CAP_W-1:0]     cfg_wdata,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 s_tlast,
    input  logic                 fifo_full,
    input  back_status_t         back_status,
    output logic                 push,
    output item_t                push_item
);

    logic [CAP_W-1:0] capacity_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= '0;
        end else if (cfg_we) begin
            capacity_reg <= cfg_wdata;
        end
    end

    // hold off while the queue is full or the table is being wiped
    assign s_tready = !fifo_full && !back_status.clearing;
    assign push     = s_tvalid && s_tready;

    always_comb begin
        push_item.weight = s_tdata[WEIGHT_W-1:0];
        push_item.value  = s_tdata[WEIGHT_W +: VALUE_W];
        push_item.last   = s_tlast;
        push_item.cap    = eff_capacity(capacity_reg);
        push_item.fits   = 32'(push_item.weight) <= 32'(push_item.cap);
    end

endmodule

>>> hw/rtl/ksdp_fifo.sv
module ksdp_fifo import ksdp_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push,
    input  item_t push_item,
    input  logic  pop,
    output logic  full,
    output logic  head_valid,
    output item_t head
);

    item_t                 entries_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_CNT_W-1:0] count_reg;

    function automatic logic [FIFO_PTR_W-1:0] ptr_inc(input logic [FIFO_PTR_W-1:0] p);
        return (p == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign full       = (count_reg == FIFO_CNT_W'(FIFO_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = entries_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop) begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

>>> hw/rtl/ksdp_back.sv
module ksdp_back import ksdp_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 head_valid,
    input  item_t                head,
    output logic                 pop,
    output back_status_t         back_status,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_DRAIN,
        ST_RES_RD,
        ST_RES,
        ST_CLEAR
    } state_t;

    logic [BEST_W-1:0] table_mem [DEPTH];

    state_t            state_reg;
    item_t             cur_reg;
    logic [ADDR_W-1:0] j_reg;
    logic              p1_valid_reg;
    logic [ADDR_W-1:0] p1_addr_reg;
    logic [ADDR_W-1:0] clr_addr_reg;
    logic [BEST_W-1:0] rd_hi_reg;
    logic [BEST_W-1:0] rd_lo_reg;
    logic              out_valid_reg;
    logic [BEST_W-1:0] out_data_reg;

    logic              rd_en;
    logic [ADDR_W-1:0] rd_hi_addr;
    logic [ADDR_W-1:0] rd_lo_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [BEST_W-1:0] wr_data;
    logic [BEST_W-1:0] cand;

    assign pop                  = (state_reg == ST_IDLE) && head_valid;
    assign back_status.clearing = (state_reg == ST_CLEAR);
    assign m_tvalid             = out_valid_reg;
    assign m_tdata              = M_TDATA_W'(out_data_reg);
    assign cand                 = sat_add(rd_lo_reg, cur_reg.value);

    always_comb begin
        rd_en      = 1'b0;
        rd_hi_addr = j_reg;
        rd_lo_addr = j_reg - ADDR_W'(cur_reg.weight);
        case (state_reg)
            ST_SWEEP: begin
                rd_en = 1'b1;
            end
            ST_RES_RD: begin
                rd_en      = 1'b1;
                rd_hi_addr = cur_reg.cap;
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    // Sweep write-back lands in the cycle after its reads; downward order keeps
    // later reads off already rewritten entries.
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = p1_addr_reg;
        wr_data = (cand > rd_hi_reg) ? cand : rd_hi_reg;
        if (p1_valid_reg) begin
            wr_en = 1'b1;
        end else if (state_reg == ST_CLEAR) begin
            wr_en   = 1'b1;
            wr_addr = clr_addr_reg;
            wr_data = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            table_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_hi_reg <= table_mem[rd_hi_addr];
            rd_lo_reg <= table_mem[rd_lo_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            p1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            // result register: load on readout, drop once taken
            if ((state_reg == ST_RES) && (!out_valid_reg || m_tready)) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            p1_valid_reg <= (state_reg == ST_SWEEP);
            p1_addr_reg  <= j_reg;
            case (state_reg)
                ST_IDLE: begin
                    if (head_valid) begin
                        cur_reg <= head;
                        j_reg   <= head.cap;
                        if (head.fits) begin
                            state_reg <= ST_SWEEP;
                        end else if (head.last) begin
                            state_reg <= ST_RES_RD;
                        end
                    end
                end
                ST_SWEEP: begin
                    if (j_reg == ADDR_W'(cur_reg.weight)) begin
                        state_reg <= ST_DRAIN;
                    end else begin
                        j_reg <= j_reg - 1'b1;
                    end
                end
                ST_DRAIN: begin
                    state_reg <= cur_reg.last ? ST_RES_RD : ST_IDLE;
                end
                ST_RES_RD: begin
                    state_reg <= ST_RES;
                end
                ST_RES: begin
                    if (!out_valid_reg || m_tready) begin
                        out_data_reg  <= rd_hi_reg;
                        clr_addr_reg  <= '0;
                        state_reg     <= ST_CLEAR;
                    end
                end
                ST_CLEAR: begin
                    if (clr_addr_reg == ADDR_W'(MAX_CAPACITY)) begin
                        state_reg <= ST_IDLE;
                    end else begin
                        clr_addr_reg <= clr_addr_reg + 1'b1;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

>>> hw/rtl/knapsack_dp_rolling_row.sv
// 0/1 knapsack engine over a single rolling row of 1024 x 32-bit best values.
// Each s_ transfer is one object (weight, value); s_tlast marks the final
// object of a problem, after which one m_ transfer carries the best total
// value reachable within the configured capacity (saturating at all ones).
// Capacity is sampled when an object is transferred in, so write cfg_wdata
// between problems. An object whose weight w fits the capacity C sweeps
// table entries C down to w, one read-modify-write of the table per cycle
// (dual read port plus one write port), then drains; an object that does
// not fit is popped without a sweep. A last object then reads out the
// result (waiting while the output register still holds an untaken result),
// then a clearing pass writes zeros over all 1024 entries, one per
// cycle; s_tready stays low throughout the pass. The same clearing pass
// runs after reset. A 4-deep queue sits between input classification and
// the sweep engine, and the result sits in its own output register, so
// neither side waits on the other while there is room.
module knapsack_dp_rolling_row import ksdp_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,

    // capacity register
    input  logic                 cfg_we,
    input  logic [CAP_W-1:0]     cfg_wdata,     // capacity

    // object stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,       // [9:0] item_weight, [25:10] item_value
    input  logic                 s_tlast,       // last_item

    // result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata        // [31:0] max_total
);

    logic         push;
    item_t        push_item;
    logic         fifo_full;
    logic         head_valid;
    item_t        head;
    logic         pop;
    back_status_t back_status;

    // front: capacity register, field unpack, fit check
    ksdp_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .fifo_full   (fifo_full),
        .back_status (back_status),
        .push        (push),
        .push_item   (push_item)
    );

    // decouples transfer acceptance from the sweep
    ksdp_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_item  (push_item),
        .pop        (pop),
        .full       (fifo_full),
        .head_valid (head_valid),
        .head       (head)
    );

    // back: table memory, downward sweep, result readout, clearing pass
    ksdp_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .head_valid  (head_valid),
        .head        (head),
        .pop         (pop),
        .back_status (back_status),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

endmodule

>>> hw/rtl/ksdp_checker.sv
module ksdp_checker import ksdp_pkg::*; (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // reset starts the clearing pass, so no object is taken right after it
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !s_tready)
        else $error("input ready right after reset");

    // reset empties the result register
    a_reset_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // every new result is followed by the table wipe
    a_result_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> !s_tready)
        else $error("input ready while a fresh result starts the wipe");

endmodule

bind knapsack_dp_rolling_row ksdp_checker u_checker (.*);

>>> tb/knapsack_dp_rolling_row_tb.sv
module knapsack_dp_rolling_row_tb;
    import ksdp_pkg::*;

    // no transfer on either side for this many cycles ends the run
    localparam int STALL_LIMIT   = 30000;
    // receiver hold-off used to back the block up into its input
    localparam int LONG_HOLD     = 4000;
    // settle times before a capacity write: a result-free tail can leave
    // up to five full sweeps in flight; after a result only the clear pass
    localparam int SETTLE_SWEEPS = 6500;
    localparam int SETTLE_CLEAR  = 1200;
    localparam int RANDOM_ITEMS  = 555;

    typedef struct {
        logic [WEIGHT_W-1:0] weight;
        logic [VALUE_W-1:0]  value;
        logic                is_last;
    } knap_obj_t;

    logic                 aclk;
    logic                 aresetn   = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CAP_W-1:0]     cfg_wdata = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;   // [9:0] item_weight, [25:10] item_value
    logic                 s_tlast   = 1'b0; // last_item
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;          // [31:0] max_total

    knapsack_dp_rolling_row uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // pending objects, and best values predicted but not yet seen
    knap_obj_t        obj_q[$];
    logic [BEST_W-1:0] best_q[$];

    // shadow of the block: capacity register and the rolling row
    logic [CAP_W-1:0]  cur_cap = '0;
    logic [BEST_W-1:0] best_row [0:DEPTH-1] = '{default: '0};

    knap_obj_t   in_flight;
    int unsigned send_wait = 0;
    int unsigned rx_wait   = 0;
    int unsigned hold_left = 0;
    int unsigned tx_gap_max = 11;
    int unsigned rx_gap_max = 11;
    logic        long_hold_req  = 1'b0;
    logic        long_hold_done = 1'b0;
    logic        tail_is_last   = 1'b1;
    int unsigned stall_cycles   = 0;

    int unsigned objects_sent   = 0;
    int unsigned results_seen   = 0;
    int unsigned cap_writes     = 0;
    int unsigned fault_count    = 0;

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Sender: offers queued objects with random gaps; on every s_ transfer
    // the object is folded into the shadow row, downward so each object
    // counts once, and a last object yields the expected best value.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : feed
        int          j;
        int          wt;
        logic [32:0] acc;
        if (!aresetn) begin
            s_tvalid  <= 1'b0;
            send_wait <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                wt = int'(in_flight.weight);
                if (in_flight.weight <= cur_cap) begin
                    for (j = int'(cur_cap); j >= wt; j--) begin
                        acc = {1'b0, best_row[j - wt]} + {17'b0, in_flight.value};
                        if (acc[32]) begin
                            acc[31:0] = '1;   // clamp at all ones
                        end
                        if (acc[31:0] > best_row[j]) begin
                            best_row[j] = acc[31:0];
                        end
                    end
                end
                if (in_flight.is_last) begin
                    best_q = {best_q, best_row[cur_cap]};
                    foreach (best_row[k]) best_row[k] = '0;
                end
                objects_sent++;
            end

            if (s_tvalid && !s_tready) begin
                // offer stands until taken
            end else if (send_wait != 0) begin
                send_wait <= send_wait - 1;
                s_tvalid  <= 1'b0;
            end else if (obj_q.size() != 0) begin
                in_flight = obj_q.pop_front();
                s_tvalid  <= 1'b1;
                s_tdata   <= S_TDATA_W'({in_flight.value, in_flight.weight});
                s_tlast   <= in_flight.is_last;
                send_wait <= $urandom_range(0, tx_gap_max);
            end else begin
                s_tvalid  <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random stall after each transfer, plus one long hold-off
    // on request so the output register, queue and engine back up.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : drain
        int unsigned gap;
        if (!aresetn) begin
            m_tready  <= 1'b0;
            rx_wait   <= 0;
            hold_left <= 0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= (hold_left == 1);
        end else if (long_hold_req && !long_hold_done) begin
            hold_left      <= LONG_HOLD;
            long_hold_done <= 1'b1;
            m_tready       <= 1'b0;
        end else if (m_tvalid && m_tready) begin
            gap = $urandom_range(0, rx_gap_max);
            rx_wait  <= gap;
            m_tready <= (gap == 0);
        end else if (rx_wait != 0) begin
            rx_wait  <= rx_wait - 1;
            m_tready <= (rx_wait == 1);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Result check against the oldest prediction
    always @(posedge aclk) begin : check
        logic [BEST_W-1:0] want;
        if (aresetn && m_tvalid && m_tready) begin
            if (best_q.size() == 0) begin
                $display("%0t unexpected result: expected none, got %h", $time,
                         m_tdata[BEST_W-1:0]);
                fault_count++;
            end else begin
                want = best_q.pop_front();
                if (m_tdata[BEST_W-1:0] !== want) begin
                    $display("%0t max_total mismatch: expected %h, got %h", $time,
                             want, m_tdata[BEST_W-1:0]);
                    fault_count++;
                end
                results_seen++;
            end
        end
    end

    // Watchdog: any transfer resets the count
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t watchdog: no transfer for %0d cycles, %0d results pending",
                     $time, stall_cycles, best_q.size());
            $display("status: fail");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic offer(input logic [WEIGHT_W-1:0] w, input logic [VALUE_W-1:0] v,
                         input logic is_last);
        knap_obj_t o;
        o.weight  = w;
        o.value   = v;
        o.is_last = is_last;
        obj_q = {obj_q, o};
        tail_is_last = is_last;
    endtask

    // Sender pauses until every prediction is matched, then lets the
    // engine finish its sweeps or clear pass before anything else.
    task automatic go_idle();
        while (obj_q.size() != 0 || s_tvalid || best_q.size() != 0) begin
            @(negedge aclk);
        end
        repeat (tail_is_last ? SETTLE_CLEAR : SETTLE_SWEEPS) @(negedge aclk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] c);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= c;
        cur_cap    = c;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        cap_writes++;
        @(negedge aclk);
    endtask

    // One problem of n objects; weights mostly fit, some sit at the limit,
    // some are zero and some land anywhere (often too heavy).
    task automatic random_problem(input int n);
        int                  i;
        int                  r;
        logic [WEIGHT_W-1:0] w;
        logic [VALUE_W-1:0]  v;
        for (i = 0; i < n; i++) begin
            r = $urandom_range(0, 9);
            if (r == 0)      w = '0;
            else if (r == 1) w = WEIGHT_W'($urandom_range(0, 1023));
            else if (r == 2) w = cur_cap;
            else             w = WEIGHT_W'($urandom_range(0, int'(cur_cap)));
            r = $urandom_range(0, 7);
            if (r == 0)      v = '1;
            else if (r == 1) v = VALUE_W'($urandom_range(0, 3));
            else             v = VALUE_W'($urandom);
            offer(w, v, i == n - 1);
        end
    endtask

    initial begin : stimulus
        int          i;
        int          r;
        int          n;
        int          n_prob;
        int unsigned rand_objects;
        logic [CAP_W-1:0] c;

        rand_objects = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // capacity still at its reset value of zero: zero weight fills entry 0,
        // a too-heavy last object still reports, and a lone misfit gives zero
        offer(10'd0, 16'hFFFF, 1'b0);
        offer(10'd1023, 16'h0001, 1'b1);
        offer(10'd7, 16'h0000, 1'b1);
        go_idle();

        // widest table, extreme weights and alternating value bits
        write_capacity(10'd1023);
        offer(10'd1023, 16'hFFFF, 1'b0);
        offer(10'd0, 16'h8000, 1'b0);
        offer(10'd1, 16'h0001, 1'b0);
        offer(10'd512, 16'hAAAA, 1'b0);
        offer(10'd511, 16'h5555, 1'b1);
        go_idle();

        // capacity lowered in the middle of a problem
        write_capacity(10'd10);
        offer(10'd3, 16'd5, 1'b0);
        offer(10'd4, 16'd6, 1'b0);
        go_idle();
        write_capacity(10'd5);
        offer(10'd2, 16'd9, 1'b0);
        offer(10'd5, 16'd20, 1'b1);
        go_idle();

        // capacity raised in the middle of a problem
        write_capacity(10'd4);
        offer(10'd1, 16'd100, 1'b0);
        go_idle();
        write_capacity(10'd9);
        offer(10'd2, 16'd50, 1'b0);
        offer(10'd9, 16'd1, 1'b1);
        go_idle();

        // long receiver hold-off while single-object problems keep coming,
        // so results pile up behind the output register and s_tready drops
        write_capacity(10'd3);
        tx_gap_max    = 0;
        long_hold_req = 1'b1;
        repeat (3) @(negedge aclk);
        for (i = 0; i < 10; i++) begin
            offer(WEIGHT_W'($urandom_range(0, 3)), VALUE_W'($urandom), 1'b1);
        end
        go_idle();

        // random phases: new capacity, gap profile and a few problems each
        while (rand_objects < RANDOM_ITEMS) begin
            r = $urandom_range(0, 19);
            if (r == 0)      c = '0;
            else if (r == 1) c = '1;
            else if (r == 2) c = CAP_W'($urandom_range(512, 1022));
            else if (r < 6)  c = CAP_W'($urandom_range(41, 200));
            else             c = CAP_W'($urandom_range(1, 40));
            go_idle();
            write_capacity(c);
            tx_gap_max = ($urandom_range(0, 4) == 0) ? 0 : 11;
            rx_gap_max = ($urandom_range(0, 4) == 0) ? 0 : 11;
            // big tables sweep slowly: keep those problems short
            n_prob = (c >= 512) ? 1 : $urandom_range(1, 3);
            repeat (n_prob) begin
                n = (c >= 512) ? $urandom_range(1, 4) : $urandom_range(1, 8);
                random_problem(n);
                rand_objects += n;
            end
        end

        go_idle();
        $display("covered %0d objects, %0d results checked, %0d capacity writes,",
                 objects_sent, results_seen, cap_writes);
        $display("incl. mid-problem capacity changes, misfits, zero weights and a long output stall");
        if (fault_count == 0 && best_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
